/* src/bcc_pkg.sv */
// Shared types, constants and register codes for the button click classifier.
package bcc_pkg;

	// Number of button slots the 3-bit index can reach
	localparam int BTN_SLOTS = 8;
	localparam int NUM_BUTTONS_DEF = 8;

	// Result queue between classifier and output stage
	localparam int QDEPTH = 2;

	// Field widths
	localparam int IDX_BITS = 3;
	localparam int TIME_BITS = 32;
	localparam int MS_BITS = 16;
	localparam int TALLY_BITS = 3;

	// Event codes
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_SHORT = 2'd1;
	localparam logic [1:0] EV_DOUBLE = 2'd2;
	localparam logic [1:0] EV_LONG = 2'd3;

	localparam logic [TALLY_BITS-1:0] TALLY_MAX = 3'd7;
	localparam logic [TALLY_BITS-1:0] TALLY_ONE = 3'd1;
	localparam logic [TALLY_BITS-1:0] TALLY_TWO = 3'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_HOLD_LIMIT = 2'd0;
	localparam logic [1:0] CFG_CLICK_MAX = 2'd1;
	localparam logic [1:0] CFG_DOUBLE_GAP = 2'd2;

	// Reset values of the configuration registers
	localparam logic [MS_BITS-1:0] HOLD_LIMIT_RST = 16'd800;
	localparam logic [MS_BITS-1:0] CLICK_MAX_RST = 16'd300;
	localparam logic [MS_BITS-1:0] DOUBLE_GAP_RST = 16'd400;

	typedef struct packed {
		logic [IDX_BITS-1:0] button_index;
		logic is_pressed;
		logic [TIME_BITS-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0] event_code;
		logic [IDX_BITS-1:0] event_button;
	} out_item_t;

	typedef struct packed {
		logic [MS_BITS-1:0] hold_limit_ms;
		logic [MS_BITS-1:0] click_max_ms;
		logic [MS_BITS-1:0] double_gap_ms;
	} cfg_t;

	// Front to queue: one result beat
	typedef struct packed {
		logic valid;
		out_item_t data;
	} q_push_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* src/bcc_front.sv */
// Front end: input register, per-button state file and event classification.
module bcc_front #(
	parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  bcc_pkg::in_item_t in_data,
	input  bcc_pkg::cfg_t cfg,
	output bcc_pkg::q_push_t push,
	input  bcc_pkg::q_status_t qstat
);

	localparam int DEPTH = (NUM_BUTTONS < bcc_pkg::BTN_SLOTS) ? NUM_BUTTONS : bcc_pkg::BTN_SLOTS;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	bcc_pkg::in_item_t item_s1;
	logic valid_s1;
	logic move;

	// Per-button state
	logic [bcc_pkg::TIME_BITS-1:0] press_q [DEPTH];
	logic [bcc_pkg::TIME_BITS-1:0] first_q [DEPTH];
	logic [bcc_pkg::TALLY_BITS-1:0] tally_q [DEPTH];
	logic [DEPTH-1:0] held_q;
	logic [DEPTH-1:0] long_q;
	logic [DEPTH-1:0] pend_q;

	// Selected entry and its next value
	logic [IDX_W-1:0] idx;
	logic in_range;
	logic [bcc_pkg::TIME_BITS-1:0] press_n, first_n;
	logic [bcc_pkg::TALLY_BITS-1:0] tally_n;
	logic held_n, long_n, pend_n;
	logic [1:0] code;

	// Input register: accept when empty or draining into the queue
	assign move = valid_s1 && !qstat.full;
	assign in_stall = valid_s1 && qstat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	assign idx = item_s1.button_index[IDX_W-1:0];
	assign in_range = int'(item_s1.button_index) < NUM_BUTTONS;

	// Classify the held sample against its button's record
	always_comb begin
		logic [bcc_pkg::TIME_BITS-1:0] diff_p;
		logic [bcc_pkg::TIME_BITS-1:0] diff_f;
		logic [bcc_pkg::TALLY_BITS-1:0] t1;
		logic first_set;
		diff_p = item_s1.now_ms - press_q[idx];
		diff_f = item_s1.now_ms - first_q[idx];
		press_n = press_q[idx];
		first_n = first_q[idx];
		tally_n = tally_q[idx];
		held_n = held_q[idx];
		long_n = long_q[idx];
		pend_n = pend_q[idx];
		code = bcc_pkg::EV_NONE;
		t1 = tally_q[idx];
		first_set = 1'b0;
		if (item_s1.is_pressed) begin
			if (!held_q[idx]) begin
				// new press: start timing; elapsed is zero so no long press yet
				press_n = item_s1.now_ms;
				held_n = 1'b1;
				long_n = 1'b0;
			end else if (!long_q[idx] && diff_p > {16'd0, cfg.hold_limit_ms}) begin
				long_n = 1'b1;
				tally_n = '0;
				pend_n = 1'b0;
				code = bcc_pkg::EV_LONG;
			end
		end else begin
			if (held_q[idx]) begin
				held_n = 1'b0;
				if (diff_p < {16'd0, cfg.click_max_ms} && !long_q[idx]) begin
					t1 = (tally_q[idx] == bcc_pkg::TALLY_MAX) ? bcc_pkg::TALLY_MAX
						: tally_q[idx] + 3'd1;
					tally_n = t1;
					if (t1 == bcc_pkg::TALLY_ONE) begin
						first_n = item_s1.now_ms;
						pend_n = 1'b1;
						first_set = 1'b1;
					end else if (t1 == bcc_pkg::TALLY_TWO &&
						diff_f < {16'd0, cfg.double_gap_ms}) begin
						pend_n = 1'b0;
						tally_n = '0;
						code = bcc_pkg::EV_DOUBLE;
					end
				end
			end
			// pending window expiry; a click recorded just now has zero age
			if (pend_n && !first_set && diff_f > {16'd0, cfg.double_gap_ms}) begin
				pend_n = 1'b0;
				if (tally_n == bcc_pkg::TALLY_ONE) begin
					code = bcc_pkg::EV_SHORT;
				end
				tally_n = '0;
			end
		end
		if (!in_range) begin
			code = bcc_pkg::EV_NONE;
		end
	end

	// State file write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				press_q[i] <= '0;
				first_q[i] <= '0;
				tally_q[i] <= '0;
			end
			held_q <= '0;
			long_q <= '0;
			pend_q <= '0;
		end else if (move && in_range) begin
			press_q[idx] <= press_n;
			first_q[idx] <= first_n;
			tally_q[idx] <= tally_n;
			held_q[idx] <= held_n;
			long_q[idx] <= long_n;
			pend_q[idx] <= pend_n;
		end
	end

	// Result beat into the queue
	always_comb begin
		push.valid = move;
		push.data.event_code = code;
		push.data.event_button = (code != bcc_pkg::EV_NONE) ? item_s1.button_index : '0;
	end

	// An ignored index never yields an event
	a_range_none: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !in_range |-> push.data.event_code == bcc_pkg::EV_NONE)
		else $error("event on out-of-range button");

	// A long press marks the button as reported
	a_long_mark: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.data.event_code == bcc_pkg::EV_LONG
		|=> long_q[$past(idx)] && !pend_q[$past(idx)])
		else $error("long press not recorded");

	// A double click leaves the button with no pending click and zero tally
	a_double_clear: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && push.data.event_code == bcc_pkg::EV_DOUBLE
		|=> !pend_q[$past(idx)] && tally_q[$past(idx)] == '0)
		else $error("double click left state behind");

endmodule

/* src/bcc_queue.sv */
// Short result queue between the classifier and the output stage.
module bcc_queue (
	input  logic clk,
	input  logic arst_n,
	input  bcc_pkg::q_push_t push,
	input  logic pop,
	output bcc_pkg::out_item_t head,
	output bcc_pkg::q_status_t qstat
);

	localparam int PTR_W = (bcc_pkg::QDEPTH > 1) ? $clog2(bcc_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(bcc_pkg::QDEPTH + 1);

	bcc_pkg::out_item_t mem [bcc_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign qstat.full = count_q == CNT_W'(bcc_pkg::QDEPTH);
	assign qstat.empty = count_q == '0;
	assign do_push = push.valid && !qstat.full;
	assign do_pop = pop && !qstat.empty;
	assign head = mem[rd_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(bcc_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(bcc_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push.data;
		end
	end

	// The front never offers a beat the queue cannot take
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !qstat.full)
		else $error("push into full queue");

endmodule

/* src/bcc_back.sv */
// Back end: output register that drains the result queue.
module bcc_back (
	input  logic clk,
	input  logic arst_n,
	input  bcc_pkg::out_item_t head,
	input  bcc_pkg::q_status_t qstat,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output bcc_pkg::out_item_t out_data
);

	logic valid_q;
	bcc_pkg::out_item_t data_q;

	// Load a new beat when the register is empty or being taken
	assign pop = !qstat.empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

/* src/button_click_classifier_top.sv */
// Top level of the button click classifier: configuration registers and datapath.
//
// Each accepted scan beat (button index, pressed level, millisecond time) yields
// exactly one result beat: short click, double click, long press, or none, in
// scan order. One beat per cycle is sustained in both directions while out_stall
// is low; each result passes through the input register, the two-entry result
// queue and the output register. Per-button state is read, updated and written
// back in the input stage as each scan leaves it, so consecutive scans of the
// same button need no forwarding. Indexes at or above NUM_BUTTONS give no event
// and leave state alone. Configuration writes are always ready and take effect
// for the next classified scan; indexes beyond the third are ignored.
module button_click_classifier_top #(
	parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  bcc_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output bcc_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [bcc_pkg::MS_BITS-1:0] cfg_data
);

	bcc_pkg::cfg_t cfg_q;
	bcc_pkg::q_push_t push;
	bcc_pkg::q_status_t qstat;
	bcc_pkg::out_item_t head;
	logic pop;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_limit_ms <= bcc_pkg::HOLD_LIMIT_RST;
			cfg_q.click_max_ms <= bcc_pkg::CLICK_MAX_RST;
			cfg_q.double_gap_ms <= bcc_pkg::DOUBLE_GAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bcc_pkg::CFG_HOLD_LIMIT: cfg_q.hold_limit_ms <= cfg_data;
				bcc_pkg::CFG_CLICK_MAX: cfg_q.click_max_ms <= cfg_data;
				bcc_pkg::CFG_DOUBLE_GAP: cfg_q.double_gap_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	bcc_front #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.cfg(cfg_q),
		.push(push),
		.qstat(qstat)
	);

	bcc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.head(head),
		.qstat(qstat)
	);

	bcc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.qstat(qstat),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

/* tb/button_click_classifier_top_tb.sv */
// Self-checking testbench for the button click classifier: directed and random scans.
module button_click_classifier_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CFG_SPARE = 2'd3;	// unmapped register index, writes are dropped
	localparam int N_BTN = 8;
	localparam int RANDOM_ITEMS = 1350;
	localparam int PHASES = 6;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 20;

	typedef enum int {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;

	// Per-button click classifier prediction and the queue of events still due
	class click_scoreboard;
		logic [bcc_pkg::TIME_BITS-1:0] hold_limit, click_max, double_gap;
		logic [bcc_pkg::TIME_BITS-1:0] press_time[N_BTN];
		logic [bcc_pkg::TIME_BITS-1:0] click_time[N_BTN];
		bit held[N_BTN];
		bit long_done[N_BTN];
		bit click_open[N_BTN];
		logic [bcc_pkg::TALLY_BITS-1:0] tally[N_BTN];
		bcc_pkg::out_item_t events_due[$];
		int fails;

		function new();
			hold_limit = {16'd0, bcc_pkg::HOLD_LIMIT_RST};
			click_max = {16'd0, bcc_pkg::CLICK_MAX_RST};
			double_gap = {16'd0, bcc_pkg::DOUBLE_GAP_RST};
			for (int i = 0; i < N_BTN; i++) begin
				press_time[i] = '0;
				click_time[i] = '0;
				held[i] = 1'b0;
				long_done[i] = 1'b0;
				click_open[i] = 1'b0;
				tally[i] = '0;
			end
			fails = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [bcc_pkg::MS_BITS-1:0] val);
			case (idx)
			bcc_pkg::CFG_HOLD_LIMIT: hold_limit = {16'd0, val};
			bcc_pkg::CFG_CLICK_MAX: click_max = {16'd0, val};
			bcc_pkg::CFG_DOUBLE_GAP: double_gap = {16'd0, val};
			default: ;
			endcase
		endfunction

		// Classify one accepted scan beat and queue the event it gives
		function void note_scan(bcc_pkg::in_item_t s);
			int b;
			logic [bcc_pkg::TIME_BITS-1:0] now, held_for, since_click;
			logic [1:0] code;
			bcc_pkg::out_item_t ev;
			b = s.button_index;
			now = s.now_ms;
			code = bcc_pkg::EV_NONE;
			if (b < bcc_pkg::NUM_BUTTONS_DEF) begin
				if (s.is_pressed) begin
					if (!held[b]) begin
						press_time[b] = now;
						held[b] = 1'b1;
						long_done[b] = 1'b0;
					end
					held_for = now - press_time[b];
					if (!long_done[b] && held_for > hold_limit) begin
						long_done[b] = 1'b1;
						tally[b] = '0;
						click_open[b] = 1'b0;
						code = bcc_pkg::EV_LONG;
					end
				end else begin
					if (held[b]) begin
						held[b] = 1'b0;
						held_for = now - press_time[b];
						if (held_for < click_max && !long_done[b]) begin
							if (tally[b] < bcc_pkg::TALLY_MAX)
								tally[b] = tally[b] + 1'b1;
							since_click = now - click_time[b];
							if (tally[b] == bcc_pkg::TALLY_ONE) begin
								click_time[b] = now;
								click_open[b] = 1'b1;
							end else if (tally[b] == bcc_pkg::TALLY_TWO &&
								since_click < double_gap) begin
								click_open[b] = 1'b0;
								tally[b] = '0;
								code = bcc_pkg::EV_DOUBLE;
							end
						end
					end
					// pending click window ran out: lone click becomes a short click
					since_click = now - click_time[b];
					if (click_open[b] && since_click > double_gap) begin
						click_open[b] = 1'b0;
						if (tally[b] == bcc_pkg::TALLY_ONE)
							code = bcc_pkg::EV_SHORT;
						tally[b] = '0;
					end
				end
			end
			ev.event_code = code;
			ev.event_button = (code != bcc_pkg::EV_NONE) ? s.button_index : '0;
			events_due.push_back(ev);
		endfunction

		function void report(string msg);
			fails++;
			if (fails <= 10)
				$display("%0t ns: %s", $time, msg);
		endfunction

		// Compare one accepted result beat with the oldest event due
		function void check_result(bcc_pkg::out_item_t r);
			bcc_pkg::out_item_t want;
			if (events_due.size() == 0) begin
				report($sformatf("result code %0d button %0d with no event due",
					r.event_code, r.event_button));
				return;
			end
			want = events_due.pop_front();
			if (r.event_code !== want.event_code)
				report($sformatf("event_code: expected %0d, got %0d",
					want.event_code, r.event_code));
			if (r.event_button !== want.event_button)
				report($sformatf("event_button: expected %0d, got %0d",
					want.event_button, r.event_button));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	bcc_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bcc_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = bcc_pkg::CFG_HOLD_LIMIT;
	logic [bcc_pkg::MS_BITS-1:0] cfg_data = '0;

	click_scoreboard sb;
	logic [bcc_pkg::TIME_BITS-1:0] btn_clock[N_BTN];
	int items_sent = 0;
	int burst_left = 0;
	int gap_max = 0;
	bit sender_idles = 1'b0;
	rx_mode_t rx_mode = RX_STEADY;
	int hold_req = 0;
	int hold_done = 0;
	int hold_left = 0;
	int rx_tick = 0;

	button_click_classifier_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Result side: check accepted beats, then pick the next stall level
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_left = HOLD_CYCLES;
		end
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (rx_mode)
			RX_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
			RX_PATTERN: out_stall <= ((rx_tick % 13) < 5) || ((rx_tick % 29) == 0);
			default: out_stall <= 1'b0;
			endcase
		end
	end

	// Offer one scan beat, idling between bursts when sender_idles is set, and wait until it is taken
	task automatic send_scan(input int b, input bit pressed,
		input logic [bcc_pkg::TIME_BITS-1:0] t);
		bcc_pkg::in_item_t s;
		int gap;
		s.button_index = b[bcc_pkg::IDX_BITS-1:0];
		s.is_pressed = pressed;
		s.now_ms = t;
		if (sender_idles && burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		in_data <= s;
		do @(posedge clk); while (in_stall);
		sb.note_scan(s);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// Stop offering and wait until every event due has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.events_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three thresholds, and optionally the unmapped index
	task automatic load_config(input logic [bcc_pkg::MS_BITS-1:0] lp,
		input logic [bcc_pkg::MS_BITS-1:0] cm,
		input logic [bcc_pkg::MS_BITS-1:0] dg, input bit poke_spare);
		logic [1:0] codes[4];
		logic [bcc_pkg::MS_BITS-1:0] vals[4];
		codes = '{bcc_pkg::CFG_HOLD_LIMIT, bcc_pkg::CFG_CLICK_MAX, bcc_pkg::CFG_DOUBLE_GAP,
			CFG_SPARE};
		vals = '{lp, cm, dg, 16'($urandom)};
		for (int i = 0; i < (poke_spare ? 4 : 3); i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= codes[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(codes[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// Duration around a threshold: edges and below-threshold values favored
	function automatic logic [bcc_pkg::TIME_BITS-1:0] near(
		input logic [bcc_pkg::TIME_BITS-1:0] lim);
		case ($urandom_range(0, 8))
		0: return '0;
		1: return (lim == 0) ? '0 : lim - 1;
		2: return lim;
		3: return lim + 1;
		8: return $urandom_range(0, lim * 2 + 2);
		default: return (lim == 0) ? '0 : $urandom_range(0, lim - 1);
		endcase
	endfunction

	// One random gesture on one button, mostly well formed
	task automatic run_gesture();
		int b, n;
		logic [bcc_pkg::TIME_BITS-1:0] t, first, rel, d;
		b = $urandom_range(0, N_BTN - 1);
		if ($urandom_range(0, 15) == 0)
			btn_clock[b] = 32'hFFFF_FFFF - $urandom_range(0, 3000);
		t = btn_clock[b] + $urandom_range(1, 50);
		case ($urandom_range(0, 9))
		0, 1, 2: begin
			// single click, sometimes held samples, sometimes a poll after
			d = near(sb.click_max);
			send_scan(b, 1'b1, t);
			if ($urandom_range(0, 2) == 0)
				send_scan(b, 1'b1, t + $urandom_range(0, d));
			t = t + d;
			send_scan(b, 1'b0, t);
			if ($urandom_range(0, 1)) begin
				t = t + near(sb.double_gap);
				send_scan(b, 1'b0, t);
			end
		end
		3, 4: begin
			// two clicks, second release near the double-click window
			send_scan(b, 1'b1, t);
			first = t + near(sb.click_max);
			send_scan(b, 1'b0, first);
			rel = first + near(sb.double_gap);
			d = near(sb.click_max);
			if (d > rel - first)
				d = rel - first;
			send_scan(b, 1'b1, rel - d);
			send_scan(b, 1'b0, rel);
			t = rel;
			if ($urandom_range(0, 2) == 0) begin
				t = t + near(sb.double_gap);
				send_scan(b, 1'b0, t);
			end
		end
		5: begin
			// long hold with samples around the threshold
			send_scan(b, 1'b1, t);
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				send_scan(b, 1'b1, t + near(sb.hold_limit));
			t = t + sb.hold_limit + $urandom_range(0, 500);
			send_scan(b, 1'b0, t);
		end
		6: begin
			// click train on the window edge: tally climbs and saturates
			send_scan(b, 1'b1, t);
			send_scan(b, 1'b0, t);
			first = t;
			n = $urandom_range(2, 10);
			for (int i = 0; i < n; i++) begin
				rel = (i == 0) ? first + sb.double_gap :
					first + $urandom_range(0, sb.double_gap);
				send_scan(b, 1'b1, rel);
				send_scan(b, 1'b0, rel);
			end
			t = first + sb.double_gap + 1;
			send_scan(b, 1'b0, t);
		end
		7: begin
			// release poll only
			t = t + near(sb.double_gap);
			send_scan(b, 1'b0, t);
		end
		8: begin
			// noise: any button, any level, any time
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				send_scan($urandom_range(0, N_BTN - 1), 1'($urandom_range(0, 1)), $urandom);
		end
		default: begin
			// broken gesture: random levels on one button
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++) begin
				t = t + $urandom_range(0, sb.hold_limit + sb.double_gap + 2);
				send_scan(b, 1'($urandom_range(0, 1)), t);
			end
		end
		endcase
		btn_clock[b] = t;
	endtask

	task automatic run_phase(input logic [bcc_pkg::MS_BITS-1:0] lp,
		input logic [bcc_pkg::MS_BITS-1:0] cm,
		input logic [bcc_pkg::MS_BITS-1:0] dg, input bit poke_spare, input rx_mode_t mode,
		input bit idles, input bit squeeze);
		int goal;
		bit held_off;
		load_config(lp, cm, dg, poke_spare);
		rx_mode = mode;
		sender_idles = idles;
		gap_max = $urandom_range(1, 8);
		burst_left = 0;
		held_off = 1'b0;
		goal = items_sent + RANDOM_ITEMS / PHASES;
		while (items_sent < goal) begin
			// receiver holds off while scans keep coming, so the block backs up
			if (squeeze && !held_off && items_sent > goal - RANDOM_ITEMS / PHASES + 20) begin
				hold_req <= hold_req + 1;
				held_off = 1'b1;
			end
			run_gesture();
		end
		drain();
	endtask

	initial begin
		for (int i = 0; i < N_BTN; i++)
			btn_clock[i] = $urandom;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part at the reset thresholds (800 / 300 / 400)
		send_scan(0, 1'b1, 32'd1000);	// click, then short click once the window passes
		send_scan(0, 1'b0, 32'd1100);
		send_scan(0, 1'b0, 32'd1600);
		send_scan(1, 1'b1, 32'd2000);	// double click
		send_scan(1, 1'b0, 32'd2050);
		send_scan(1, 1'b1, 32'd2100);
		send_scan(1, 1'b0, 32'd2150);
		send_scan(2, 1'b1, 32'd3000);	// long press, release gives nothing
		send_scan(2, 1'b1, 32'd3801);
		send_scan(2, 1'b0, 32'd3900);
		send_scan(3, 1'b1, 32'hFFFF_FF00);	// click across time wrap
		send_scan(3, 1'b0, 32'h0000_0010);
		send_scan(3, 1'b0, 32'h0000_0200);
		send_scan(4, 1'b1, 32'd5000);	// hold exactly at the long threshold, then past it
		send_scan(4, 1'b1, 32'd5800);
		send_scan(4, 1'b1, 32'd5801);
		send_scan(5, 1'b1, 32'd6000);	// release exactly at the click limit: no click
		send_scan(5, 1'b0, 32'd6300);
		send_scan(7, 1'b1, 32'd7000);	// second click too late: no event at all
		send_scan(7, 1'b0, 32'd7100);
		send_scan(7, 1'b1, 32'd7600);
		send_scan(7, 1'b0, 32'd7700);
		send_scan(6, 1'b1, 32'd8000);	// extra clicks on the window edge give no event
		send_scan(6, 1'b0, 32'd8000);
		send_scan(6, 1'b1, 32'd8400);
		send_scan(6, 1'b0, 32'd8400);
		send_scan(6, 1'b0, 32'd8401);
		drain();

		run_phase('0, '0, '0, 1'b1, RX_RANDOM, 1'b1, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, RX_PATTERN, 1'b1, 1'b0);
		run_phase(16'd800, 16'd300, 16'd400, 1'b0, RX_RANDOM, 1'b0, 1'b1);
		run_phase(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
			16'($urandom_range(0, 2000)), 1'b0, RX_STEADY, 1'b0, 1'b0);
		run_phase(16'd20, 16'd10, 16'd15, 1'b1, RX_RANDOM, 1'b1, 1'b0);
		run_phase(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, RX_PATTERN, 1'b1, 1'b0);

		if (sb.fails == 0)
			$display("button_click_classifier_top_tb passed");
		else
			$display("button_click_classifier_top_tb failed");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("button_click_classifier_top_tb failed");
		$finish;
	end

endmodule

/* sim.f */
src/bcc_pkg.sv
src/bcc_front.sv
src/bcc_queue.sv
src/bcc_back.sv
src/button_click_classifier_top.sv
tb/button_click_classifier_top_tb.sv
